@@ src/sctq_pkg.sv @@
`default_nettype none

package sctq_pkg;

   localparam int unsigned CHANNELS_DEFAULT = 4;
   localparam int unsigned CHANNELS_MAX     = 8;

   localparam int unsigned LEVEL_W    = 16;
   localparam int unsigned BTIME_W    = 16;
   localparam int unsigned TIMER_W    = 24;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned CHAN_W     = 3;
   localparam int unsigned POS_W      = 4;
   localparam int unsigned TALLY_W    = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 24;

   localparam logic [STATUS_W-1:0] STATUS_LISTEN = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FOUND  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_AMBIG  = 2'd2;

   localparam logic ACT_PEAK  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_TAP_LEVEL    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_QUIET_LEVEL  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SUSTAIN_TIME = 2'd2;

   localparam logic signed [LEVEL_W-1:0] TAP_LEVEL_RESET   = -16'sd5120;
   localparam logic signed [LEVEL_W-1:0] QUIET_LEVEL_RESET = -16'sd10240;
   localparam logic [TIMER_W-1:0]        SUSTAIN_RESET     = 24'd200000;
   localparam logic [TIMER_W-1:0]        TIMER_MAX         = 24'hFFFFFF;

   localparam logic [POS_W-1:0]   POS_MAX   = 4'd15;
   localparam logic [TALLY_W-1:0] TALLY_MAX = 2'd2;

endpackage

`default_nettype wire

@@ src/sctq_if.sv @@
`default_nettype none

interface sctq_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     action;
   logic signed [sctq_pkg::LEVEL_W-1:0]      peak_level;
   logic                                     block_end;
   logic        [sctq_pkg::BTIME_W-1:0]      block_time;

   modport source (output valid, action, peak_level, block_end, block_time, input ready);
   modport sink   (input valid, action, peak_level, block_end, block_time, output ready);
endinterface

interface sctq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [sctq_pkg::STATUS_W-1:0]       status;
   logic [sctq_pkg::CHAN_W-1:0]         tapped_channel;

   modport source (output valid, status, tapped_channel, input ready);
   modport sink   (input valid, status, tapped_channel, output ready);
endinterface

`default_nettype wire

@@ src/single_channel_tap_qualifier_top.sv @@
// Channel   Dir  Handshake       Payload
// req_if    in   valid/ready     action, peak_level, block_end, block_time
// rsp_if    out  valid/ready     status, tapped_channel
// csr_*     in   csr_wr_en       csr_index, csr_wdata (no read-back)
//
// One transaction per cycle unless a result stalls: an input register feeds
// one compare/add/compare pass that updates the detector state and loads the
// result register, from which a result (block end or clear action) is taken.
// Synchronous reset empties both registers and resets detector state and CSRs.
// While rsp_ready is low the result holds; requests that produce no result
// keep flowing, others stall in the input register.
`default_nettype none

module single_channel_tap_qualifier_top #(
   parameter int unsigned CHANNELS = sctq_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   sctq_req_if.sink                                 req_if,
   sctq_rsp_if.source                               rsp_if,
   input  wire logic                                csr_wr_en,
   input  wire logic [sctq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sctq_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [sctq_pkg::POS_W-1:0]    LAST_POS = sctq_pkg::POS_W'(CHANNELS - 1);
   localparam logic [sctq_pkg::CHAN_W:0]     CHAN_CNT = (sctq_pkg::CHAN_W + 1)'(CHANNELS);

   logic signed [sctq_pkg::LEVEL_W-1:0]   tap_ff;
   logic signed [sctq_pkg::LEVEL_W-1:0]   quiet_ff;
   logic        [sctq_pkg::TIMER_W-1:0]   sustain_ff;

   logic                                  in_valid_ff, in_valid_in;
   logic                                  in_action_ff;
   logic signed [sctq_pkg::LEVEL_W-1:0]   in_peak_ff;
   logic                                  in_end_ff;
   logic        [sctq_pkg::BTIME_W-1:0]   in_time_ff;

   logic [sctq_pkg::STATUS_W-1:0]         verdict_ff, verdict_in;
   logic [sctq_pkg::CHAN_W-1:0]           chosen_ff, chosen_in;
   logic [sctq_pkg::TIMER_W-1:0]          timer_ff [CHANNELS];
   logic [sctq_pkg::TIMER_W-1:0]          timer_in [CHANNELS];
   logic [sctq_pkg::POS_W-1:0]            position_ff, position_in;
   logic [sctq_pkg::TALLY_W-1:0]          tally_ff, tally_in;
   logic [sctq_pkg::CHAN_W-1:0]           lidx_ff, lidx_in;
   logic                                  noisy_ff, noisy_in;

   logic                                  out_valid_ff, out_valid_in;
   logic [sctq_pkg::STATUS_W-1:0]         out_status_ff;
   logic [sctq_pkg::CHAN_W-1:0]           out_chan_ff;

   logic                                  req_take;
   logic                                  produces;
   logic                                  advance;
   logic                                  is_loud;
   logic                                  is_noisy;
   logic [sctq_pkg::TALLY_W-1:0]          tally_upd;
   logic [sctq_pkg::CHAN_W-1:0]           lidx_upd;
   logic                                  noisy_upd;
   logic                                  judge;
   logic                                  in_range;
   logic [sctq_pkg::TIMER_W-1:0]          sel_timer;
   logic [sctq_pkg::TIMER_W:0]            sum;
   logic [sctq_pkg::TIMER_W-1:0]          sat_t;

   assign produces = (in_action_ff == sctq_pkg::ACT_CLEAR) || in_end_ff;
   assign advance  = in_valid_ff && (!produces || !out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take = req_if.valid && req_if.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = (advance && produces) || (out_valid_ff && !rsp_if.ready);

   assign is_loud   = in_peak_ff > tap_ff;
   assign is_noisy  = !is_loud && (in_peak_ff >= quiet_ff);
   assign tally_upd = (is_loud && tally_ff != sctq_pkg::TALLY_MAX) ? tally_ff + 2'd1 : tally_ff;
   assign lidx_upd  = is_loud ? position_ff[sctq_pkg::CHAN_W-1:0] : lidx_ff;
   assign noisy_upd = noisy_ff || is_noisy;
   assign judge     = in_end_ff && (verdict_ff == sctq_pkg::STATUS_LISTEN)
                      && (position_ff == LAST_POS);
   assign in_range  = {1'b0, lidx_upd} < CHAN_CNT;

   always_comb begin
      sel_timer = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (lidx_upd == sctq_pkg::CHAN_W'(i)) begin
            sel_timer = timer_ff[i];
         end
      end
   end

   assign sum   = {1'b0, sel_timer} + (sctq_pkg::TIMER_W + 1)'(in_time_ff);
   assign sat_t = sum[sctq_pkg::TIMER_W] ? sctq_pkg::TIMER_MAX : sum[sctq_pkg::TIMER_W-1:0];

   always_comb begin
      verdict_in  = verdict_ff;
      chosen_in   = chosen_ff;
      position_in = position_ff;
      tally_in    = tally_ff;
      lidx_in     = lidx_ff;
      noisy_in    = noisy_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         timer_in[i] = timer_ff[i];
      end
      if (advance) begin
         if (in_action_ff == sctq_pkg::ACT_CLEAR) begin
            verdict_in  = sctq_pkg::STATUS_LISTEN;
            chosen_in   = '0;
            position_in = '0;
            tally_in    = '0;
            lidx_in     = '0;
            noisy_in    = 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
               timer_in[i] = '0;
            end
         end else if (!in_end_ff) begin
            position_in = (position_ff == sctq_pkg::POS_MAX) ? position_ff : position_ff + 4'd1;
            tally_in    = tally_upd;
            lidx_in     = lidx_upd;
            noisy_in    = noisy_upd;
         end else begin
            position_in = '0;
            tally_in    = '0;
            lidx_in     = '0;
            noisy_in    = 1'b0;
            if (judge) begin
               if (tally_upd > 2'd1) begin
                  verdict_in = sctq_pkg::STATUS_AMBIG;
               end else if (tally_upd == 2'd0 || noisy_upd) begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     timer_in[i] = '0;
                  end
               end else if (in_range) begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     if (lidx_upd == sctq_pkg::CHAN_W'(i)) begin
                        timer_in[i] = sat_t;
                     end
                  end
                  if (sat_t >= sustain_ff) begin
                     verdict_in = sctq_pkg::STATUS_FOUND;
                     chosen_in  = lidx_upd;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff     <= sctq_pkg::TAP_LEVEL_RESET;
         quiet_ff   <= sctq_pkg::QUIET_LEVEL_RESET;
         sustain_ff <= sctq_pkg::SUSTAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            sctq_pkg::REG_TAP_LEVEL:    tap_ff     <= csr_wdata[sctq_pkg::LEVEL_W-1:0];
            sctq_pkg::REG_QUIET_LEVEL:  quiet_ff   <= csr_wdata[sctq_pkg::LEVEL_W-1:0];
            sctq_pkg::REG_SUSTAIN_TIME: sustain_ff <= csr_wdata[sctq_pkg::TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         verdict_ff   <= sctq_pkg::STATUS_LISTEN;
         chosen_ff    <= '0;
         position_ff  <= '0;
         tally_ff     <= '0;
         lidx_ff      <= '0;
         noisy_ff     <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            timer_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         verdict_ff   <= verdict_in;
         chosen_ff    <= chosen_in;
         position_ff  <= position_in;
         tally_ff     <= tally_in;
         lidx_ff      <= lidx_in;
         noisy_ff     <= noisy_in;
         for (int i = 0; i < CHANNELS; i++) begin
            timer_ff[i] <= timer_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_if.action;
         in_peak_ff   <= req_if.peak_level;
         in_end_ff    <= req_if.block_end;
         in_time_ff   <= req_if.block_time;
      end
      if (advance && produces) begin
         out_status_ff <= verdict_in;
         out_chan_ff   <= (verdict_in == sctq_pkg::STATUS_FOUND) ? chosen_in : '0;
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.status         = out_status_ff;
   assign rsp_if.tapped_channel = out_chan_ff;

endmodule

`default_nettype wire

@@ src/sctq_checker.sv @@
`default_nettype none

module sctq_checker #(
   parameter int unsigned CHANNELS = sctq_pkg::CHANNELS_DEFAULT
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [sctq_pkg::STATUS_W-1:0]   rsp_status,
   input wire logic [sctq_pkg::CHAN_W-1:0]     rsp_channel
);

   localparam logic [sctq_pkg::CHAN_W:0] CHAN_CNT = (sctq_pkg::CHAN_W + 1)'(CHANNELS);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("pipeline not empty after reset");

   a_channel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sctq_pkg::STATUS_FOUND |-> rsp_channel == '0)
      else $error("tapped channel set without identification");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sctq_pkg::STATUS_FOUND |-> {1'b0, rsp_channel} < CHAN_CNT)
      else $error("identified channel out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_channel))
      else $error("stalled result changed");

   a_req_ready_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without output backpressure");

endmodule

bind single_channel_tap_qualifier_top sctq_checker #(.CHANNELS(CHANNELS)) u_sctq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_status  (rsp_if.status),
   .rsp_channel (rsp_if.tapped_channel)
);

`default_nettype wire
